>>> rtl/philox_4x32_10_block_core_macros.svh
// Assertion macros shared by the Philox block RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PHILOX_4X32_10_BLOCK_CORE_MACROS_SVH
`define PHILOX_4X32_10_BLOCK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PHX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("philox block: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PHX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("philox block: next-cycle check failed");

`endif

>>> rtl/phx_pkg.sv
// Philox4x32 package: round count, multiplier and Weyl constants, block type
// and the single-round function. No dependencies.
package phx_pkg;

    localparam int ROUND_COUNT = 10;

    localparam logic [31:0] PHX_MUL_A  = 32'hD2511F53;
    localparam logic [31:0] PHX_MUL_B  = 32'hCD9E8D57;
    localparam logic [31:0] PHX_WEYL_A = 32'h9E3779B9;
    localparam logic [31:0] PHX_WEYL_B = 32'hBB67AE85;

    // Four-word counter block
    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } phx_block_t;

    // One Philox round: two 32x32 products, XOR with key, permute
    function automatic phx_block_t phx_round(phx_block_t w, logic [31:0] k0,
                                             logic [31:0] k1);
        logic [63:0] pa;
        logic [63:0] pb;
        phx_block_t  r;
        pa   = 64'(w.w0) * 64'(PHX_MUL_A);
        pb   = 64'(w.w2) * 64'(PHX_MUL_B);
        r.w0 = pb[63:32] ^ w.w1 ^ k0;
        r.w1 = pb[31:0];
        r.w2 = pa[63:32] ^ w.w3 ^ k1;
        r.w3 = pa[31:0];
        return r;
    endfunction

endpackage

>>> rtl/phx_if.sv
// Valid/ready channel interfaces for the Philox block: counter in,
// random words out, seed key write. Depends on nothing.
interface phx_ctr_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_counter;

    modport source (output valid, output block_counter, input ready);
    modport sink   (input valid, input block_counter, output ready);
endinterface

interface phx_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word_zero;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [31:0] word_three;

    modport source (output valid, output word_zero, output word_one,
                    output word_two, output word_three, input ready);
    modport sink   (input valid, input word_zero, input word_one,
                    input word_two, input word_three, output ready);
endinterface

interface phx_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] seed_key;

    modport source (output valid, output seed_key, input ready);
    modport sink   (input valid, input seed_key, output ready);
endinterface

>>> rtl/philox_4x32_10_block_core.sv
// Philox4x32-10 block generator top level.
// Depends on phx_pkg, phx_if.sv and philox_4x32_10_block_core_macros.svh.
//
// Takes one 64-bit block counter per beat and returns four 32-bit random words
// per beat. Sustained rate is one block per clock while rnd_out.ready is high;
// there is one Philox round per pipeline stage, each stage holding the two
// 32x32 multipliers of its round. Each stage stalls only when it is full and
// the stage after it cannot take its beat, so bubbles are squeezed out under
// back-pressure. The seed key is taken on any cfg beat (cfg.ready is always
// high) and must only change while the pipeline is empty; round keys are the
// seed plus fixed multiples of the Weyl constants.
`include "philox_4x32_10_block_core_macros.svh"

module philox_4x32_10_block_core
    import phx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    phx_cfg_if.sink     cfg,
    phx_ctr_if.sink     ctr_in,
    phx_word_if.source  rnd_out
);

    localparam int LAST = ROUND_COUNT - 1;

    logic [63:0] key_reg;

    phx_block_t  stage_reg   [ROUND_COUNT];
    phx_block_t  stage_next  [ROUND_COUNT];
    logic        valid_reg   [ROUND_COUNT];
    logic        stage_ready [ROUND_COUNT];
    phx_block_t  ctr_block;

    // Seed key register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg.valid)
        begin
            key_reg <= cfg.seed_key;
        end
    end

    // Counter words two and three start at zero
    always_comb
    begin
        ctr_block.w0 = ctr_in.block_counter[31:0];
        ctr_block.w1 = ctr_in.block_counter[63:32];
        ctr_block.w2 = '0;
        ctr_block.w3 = '0;
    end

    assign ctr_in.ready = stage_ready[0];

    // Round pipeline
    for (genvar s = 0; s < ROUND_COUNT; s++)
    begin : g_round
        localparam logic [31:0] KINC0 = 32'(64'(s) * 64'(PHX_WEYL_A));
        localparam logic [31:0] KINC1 = 32'(64'(s) * 64'(PHX_WEYL_B));

        logic [31:0] rkey0;
        logic [31:0] rkey1;
        logic        take;

        assign rkey0 = key_reg[31:0] + KINC0;
        assign rkey1 = key_reg[63:32] + KINC1;

        if (s == 0)
        begin : g_first
            assign stage_next[s] = phx_round(ctr_block, rkey0, rkey1);
            assign take          = ctr_in.valid;
        end
        else
        begin : g_mid
            assign stage_next[s] = phx_round(stage_reg[s-1], rkey0, rkey1);
            assign take          = valid_reg[s-1];
        end

        if (s == LAST)
        begin : g_tail
            assign stage_ready[s] = !valid_reg[s] || rnd_out.ready;
        end
        else
        begin : g_body
            assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];
        end

        // Valid bit travels with the beat
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= take;
            end
        end

        // Payload, no reset
        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && take)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    // Output is the last stage register
    assign rnd_out.valid      = valid_reg[LAST];
    assign rnd_out.word_zero  = stage_reg[LAST].w0;
    assign rnd_out.word_one   = stage_reg[LAST].w1;
    assign rnd_out.word_two   = stage_reg[LAST].w2;
    assign rnd_out.word_three = stage_reg[LAST].w3;

    // Checks
    `PHX_ASSERT_NEXT(a_in_lands, clk, rst_n, ctr_in.valid && ctr_in.ready, valid_reg[0])
    `PHX_ASSERT_NEXT(a_first_holds, clk, rst_n, valid_reg[0] && !stage_ready[0],
                     valid_reg[0] && $stable(stage_reg[0]))
    `PHX_ASSERT_NOW(a_ready_empty, clk, rst_n, !valid_reg[LAST], ctr_in.ready)

    if (ROUND_COUNT > 1)
    begin : g_chk
        `PHX_ASSERT_NEXT(a_tail_refill, clk, rst_n, valid_reg[LAST] && rnd_out.ready,
                         valid_reg[LAST] == $past(valid_reg[LAST-1]))
    end

endmodule
